// ===== hdl/cpcs_pkg.sv =====
package cpcs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_PERCENT = 2'd2;

  localparam logic [7:0] FRAME_WIDTH_RST   = 8'd128;
  localparam logic [6:0] FRAME_HEIGHT_RST  = 7'd64;
  localparam logic [6:0] NOISE_PERCENT_RST = 7'd95;

  localparam int NOISE_SCALE = 100;

  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] RESULT_LIMIT = 7'd64;

  localparam int START_W = 7;
  localparam int LEN_W   = 8;

  typedef struct packed {
    logic accept_en;
    logic start;
    logic read;
    logic count;
    logic sum;
    logic eval;
    logic finish;
  } cpcs_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic has_ink;
    logic found;
    logic limit;
    logic at_end;
    logic hold;
    logic out_free;
  } cpcs_stat_t;

endpackage

// ===== hdl/cpcs_datapath.sv =====
module cpcs_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [cpcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  input  logic                              in_pixel_white,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              out_segment_valid,
  output logic [cpcs_pkg::START_W-1:0]      out_segment_start,
  output logic [cpcs_pkg::LEN_W-1:0]        out_segment_width,
  output logic                              out_last_segment,
  input  cpcs_pkg::cpcs_cmd_t               cmd,
  output cpcs_pkg::cpcs_stat_t              stat
);
  import cpcs_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CBW  = CW + 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RBW  = RW + 1;
  localparam int PW   = RBW + 7;
  localparam int NCH  = (MAX_HEIGHT + 7) / 8;
  localparam int PADW = NCH * 8;

  logic [7:0] fw_r;
  logic [6:0] fh_r;
  logic [6:0] noise_r;

  logic [CW-1:0] wc_r;
  logic [RW-1:0] wr_r;
  logic          bg_r;
  logic          ink_r;
  logic [CW-1:0] left_r;
  logic [CW-1:0] right_r;
  logic [RW-1:0] top_r;
  logic [RW-1:0] bottom_r;

  logic [MAX_HEIGHT-1:0] col_mem [MAX_WIDTH];
  logic [MAX_HEIGHT-1:0] rdata_r;
  logic [MAX_HEIGHT-1:0] mask_r;
  logic [MAX_HEIGHT-1:0] mask_nxt;
  logic [PW-1:0]         thr_r;
  logic [3:0]            chunk_r [NCH];
  logic [RBW-1:0]        whites_r;

  logic [CW-1:0]      col_r;
  logic [CW-1:0]      begin_r;
  logic               in_seg_r;
  logic               pend_v_r;
  logic [START_W-1:0] pend_start_r;
  logic [LEN_W-1:0]   pend_len_r;
  logic [COUNT_W-1:0] count_r;

  logic               out_valid_r;
  logic               out_seg_valid_r;
  logic [START_W-1:0] out_start_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_last_r;

  logic [CBW-1:0] cols_eff;
  logic [RBW-1:0] rows_eff;
  logic           pix_acc;
  logic [CBW-1:0] wc_inc;
  logic [RBW-1:0] wr_inc;
  logic           col_wrap;
  logic           frame_end;
  logic           first_pix;
  logic           diff_pix;
  logic [RBW-1:0] rows_in_box;

  logic [PADW-1:0]  masked;
  logic [3:0]       chunk_nxt [NCH];
  logic [RBW-1:0]   whites_nxt;

  logic           inked;
  logic           at_end;
  logic [CW-1:0]  seg_begin;
  logic           found;
  logic [CBW-1:0] new_len;
  logic [CW+7:0]  start_pad;
  logic [CBW+7:0] len_pad;
  logic           limit;
  logic           out_free;
  logic           hold;
  logic           commit;
  logic           push_mid;
  logic           push_fin;

  always_comb begin
    if (fw_r == 8'd0) begin
      cols_eff = CBW'(1);
    end else if (int'(fw_r) > MAX_WIDTH) begin
      cols_eff = CBW'(MAX_WIDTH);
    end else begin
      cols_eff = CBW'(fw_r);
    end
    if (fh_r == 7'd0) begin
      rows_eff = RBW'(1);
    end else if (int'(fh_r) > MAX_HEIGHT) begin
      rows_eff = RBW'(MAX_HEIGHT);
    end else begin
      rows_eff = RBW'(fh_r);
    end
  end

  assign pix_acc   = in_valid && cmd.accept_en;
  assign wc_inc    = {1'b0, wc_r} + CBW'(1);
  assign wr_inc    = {1'b0, wr_r} + RBW'(1);
  assign col_wrap  = wc_inc >= cols_eff;
  assign frame_end = pix_acc && col_wrap && (wr_inc >= rows_eff);
  assign first_pix = (wc_r == '0) && (wr_r == '0);
  assign diff_pix  = !first_pix && (in_pixel_white != bg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= FRAME_WIDTH_RST;
      fh_r    <= FRAME_HEIGHT_RST;
      noise_r <= NOISE_PERCENT_RST;
      wc_r    <= '0;
      wr_r    <= '0;
      bg_r    <= 1'b0;
      ink_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          fw_r <= cfg_data;
          wc_r <= '0;
          wr_r <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          fh_r <= cfg_data[6:0];
          wc_r <= '0;
          wr_r <= '0;
        end
        CFG_NOISE_PERCENT: begin
          noise_r <= cfg_data[6:0];
          wc_r    <= '0;
          wr_r    <= '0;
        end
        default: ;
      endcase
    end else if (pix_acc) begin
      if (col_wrap) begin
        wc_r <= '0;
        wr_r <= frame_end ? '0 : wr_inc[RW-1:0];
      end else begin
        wc_r <= wc_inc[CW-1:0];
      end
      if (first_pix) begin
        bg_r  <= in_pixel_white;
        ink_r <= 1'b0;
      end else if (diff_pix && !ink_r) begin
        ink_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && !cfg_valid && diff_pix) begin
      if (!ink_r) begin
        left_r   <= wc_r;
        right_r  <= wc_r;
        top_r    <= wr_r;
        bottom_r <= wr_r;
      end else begin
        if (wc_r < left_r)   left_r   <= wc_r;
        if (wc_r > right_r)  right_r  <= wc_r;
        if (wr_r < top_r)    top_r    <= wr_r;
        if (wr_r > bottom_r) bottom_r <= wr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && !cfg_valid) begin
      col_mem[wc_r][wr_r] <= in_pixel_white;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata_r <= col_mem[col_r];
    end
  end

  assign rows_in_box = {1'b0, bottom_r} - {1'b0, top_r} + RBW'(1);

  always_comb begin
    for (int i = 0; i < MAX_HEIGHT; i++) begin
      mask_nxt[i] = (RW'(i) >= top_r) && (RW'(i) <= bottom_r);
    end
  end

  assign masked = PADW'(rdata_r & mask_r);

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      chunk_nxt[ch] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        chunk_nxt[ch] = chunk_nxt[ch] + {3'd0, masked[ch*8+b]};
      end
    end
  end

  always_comb begin
    whites_nxt = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      whites_nxt = whites_nxt + RBW'(chunk_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mask_r <= mask_nxt;
      thr_r  <= PW'(rows_in_box) * PW'(noise_r);
    end
    if (cmd.count) begin
      chunk_r <= chunk_nxt;
    end
    if (cmd.sum) begin
      whites_r <= whites_nxt;
    end
  end

  assign inked     = (PW'(whites_r) * PW'(NOISE_SCALE)) < thr_r;
  assign at_end    = col_r == right_r;
  assign seg_begin = in_seg_r ? begin_r : col_r;
  assign found     = (!inked && in_seg_r) || (at_end && inked);
  assign new_len   = inked ? ({1'b0, right_r} - {1'b0, seg_begin} + CBW'(1))
                           : ({1'b0, col_r} - {1'b0, begin_r});
  assign start_pad = {8'd0, seg_begin};
  assign len_pad   = {8'd0, new_len};
  assign limit     = (count_r + COUNT_W'(1)) == RESULT_LIMIT;
  assign out_free  = !out_valid_r || !out_stall;
  assign hold      = found && pend_v_r && !out_free;
  assign commit    = cmd.eval && !hold;
  assign push_mid  = commit && found && pend_v_r;
  assign push_fin  = cmd.finish && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seg_r <= 1'b0;
      pend_v_r <= 1'b0;
      count_r  <= '0;
    end else if (cmd.start) begin
      in_seg_r <= 1'b0;
      pend_v_r <= 1'b0;
      count_r  <= '0;
    end else if (commit) begin
      in_seg_r <= inked;
      if (found) begin
        pend_v_r <= 1'b1;
        count_r  <= count_r + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_r <= left_r;
    end else if (commit) begin
      col_r   <= col_r + CW'(1);
      begin_r <= seg_begin;
      if (found) begin
        pend_start_r <= start_pad[START_W-1:0];
        pend_len_r   <= len_pad[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_mid || push_fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid) begin
      out_seg_valid_r <= 1'b1;
      out_start_r     <= pend_start_r;
      out_len_r       <= pend_len_r;
      out_last_r      <= 1'b0;
    end else if (push_fin) begin
      out_seg_valid_r <= pend_v_r;
      out_start_r     <= pend_v_r ? pend_start_r : '0;
      out_len_r       <= pend_v_r ? pend_len_r : '0;
      out_last_r      <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_valid = out_seg_valid_r;
  assign out_segment_start = out_start_r;
  assign out_segment_width = out_len_r;
  assign out_last_segment  = out_last_r;

  assign stat.frame_end = frame_end && !cfg_valid;
  assign stat.has_ink   = ink_r;
  assign stat.found     = found;
  assign stat.limit     = limit;
  assign stat.at_end    = at_end;
  assign stat.hold      = hold;
  assign stat.out_free  = out_free;

endmodule

// ===== hdl/cpcs_ctrl.sv =====
module cpcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpcs_pkg::cpcs_stat_t stat,
  output cpcs_pkg::cpcs_cmd_t  cmd
);
  import cpcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_COUNT,
    ST_SUM,
    ST_EVAL,
    ST_FINISH
  } state_t;

  state_t    state_r;
  state_t    state_nxt;
  cpcs_cmd_t cmd_r;
  cpcs_cmd_t cmd_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (stat.frame_end) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = stat.has_ink ? ST_READ : ST_FINISH;
      end
      ST_READ:  state_nxt = ST_COUNT;
      ST_COUNT: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (!stat.hold) begin
          if ((stat.found && stat.limit) || stat.at_end) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt = '0;
    case (state_nxt)
      ST_IDLE:   cmd_nxt.accept_en = 1'b1;
      ST_START:  cmd_nxt.start     = 1'b1;
      ST_READ:   cmd_nxt.read      = 1'b1;
      ST_COUNT:  cmd_nxt.count     = 1'b1;
      ST_SUM:    cmd_nxt.sum       = 1'b1;
      ST_EVAL:   cmd_nxt.eval      = 1'b1;
      ST_FINISH: cmd_nxt.finish    = 1'b1;
      default:   cmd_nxt.accept_en = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cmd_r   <= '{accept_en: 1'b1, default: 1'b0};
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign cmd = cmd_r;

endmodule

// ===== hdl/column_projection_char_segmenter.sv =====
// column projection character segmenter
// in_ channel: one bilevel pixel per transfer, raster order, frame_width by
//   frame_height; the first pixel of a frame is taken as background
// out_ channel: the character segments of the frame, left to right, one per
//   transfer; last_segment marks the final one, and a frame without a
//   segment yields a single transfer with segment_valid low
// cfg_ channel: index 0 frame_width, 1 frame_height, 2 noise_percent; write
//   only while idle, any write restarts the frame at row 0, column 0
// throughput: one pixel per cycle while a frame streams in
// after the last pixel in_stall stays high for the column scan:
//   2 cycles for setup and finish plus 4 cycles per column of the ink box
//   (column store read, masked bit count, sum, threshold compare)
// a segment leaves once the next one is found or the scan ends, so results
//   follow their closing column by a few cycles
// when the receiver stalls the result is held in the output register; the
//   scan waits only when a second result is ready behind it
// reset: synchronous active-low; registers return to 128 x 64 and 95
//   percent, no clearing pass is needed since every frame rewrites the store
module column_projection_char_segmenter #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_pixel_white,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_segment_valid,
  output logic [6:0] out_segment_start,
  output logic [7:0] out_segment_width,
  output logic       out_last_segment
);
  import cpcs_pkg::*;

  cpcs_cmd_t  cmd;
  cpcs_stat_t stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.accept_en;

  cpcs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  cpcs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_pixel_white    (in_pixel_white),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_segment_valid (out_segment_valid),
    .out_segment_start (out_segment_start),
    .out_segment_width (out_segment_width),
    .out_last_segment  (out_last_segment),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
